// ===== rtl/core/rfp_pkg.sv =====
// Package for the RFID ASCII hex frame parser: frame geometry, byte codes,
// tag state codes, the one-hot parser mode, item and result structs.
// No dependencies; the core, the top level and the testbench import it.
package rfp_pkg;

	localparam int FRAME_DIGITS = 12;
	localparam int STORE_BYTES  = (FRAME_DIGITS + 1) / 2;
	localparam int DPOS_W       = $clog2(FRAME_DIGITS + 1);
	localparam int ID_BYTES     = 5;
	localparam int REPORT_BYTES = ID_BYTES + 1;

	localparam logic [7:0] BYTE_START = 8'h02;
	localparam logic [7:0] BYTE_END   = 8'h03;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_A     = 8'h41;
	localparam logic [7:0] HEX_TEN    = 8'd10;
	localparam logic [7:0] DEC_MAX    = 8'd9;
	localparam logic [3:0] NIBBLE_MASK = 4'hF;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_POLL = 1'b1;

	localparam logic [2:0] TAG_IDLE    = 3'd0;
	localparam logic [2:0] TAG_READING = 3'd1;
	localparam logic [2:0] TAG_ARRIVED = 3'd2;
	localparam logic [2:0] TAG_PRESENT = 3'd3;
	localparam logic [2:0] TAG_LEFT    = 3'd4;

	typedef enum logic [4:0] {
		MODE_IDLE    = 5'b00001,
		MODE_READING = 5'b00010,
		MODE_ARRIVED = 5'b00100,
		MODE_PRESENT = 5'b01000,
		MODE_LEFT    = 5'b10000
	} mode_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
		logic       card_present;
	} item_t;

	typedef struct packed {
		logic [2:0]  tag_state;
		logic        left_event;
		logic [39:0] tag_id;
		logic [7:0]  tag_check;
		logic        check_ok;
	} result_t;

	// Value of one ASCII hex character; no legality check is made.
	function automatic logic [3:0] hex_nibble(input logic [7:0] ch);
		logic [7:0] v;
		v = ch - CHAR_ZERO;
		if (v > DEC_MAX) begin
			v = ch - CHAR_A + HEX_TEN;
		end
		return v[3:0] & NIBBLE_MASK;
	endfunction

endpackage

// ===== rtl/core/rfp_ifs.sv =====
// Valid/ready channel interfaces of the RFID frame parser: the input word
// channel and the result word channel. No dependencies.
interface rfp_item_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] rx_byte;
	logic       card_present;

	modport source (output valid, cmd, rx_byte, card_present, input ready);
	modport sink   (input valid, cmd, rx_byte, card_present, output ready);
endinterface

interface rfp_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  tag_state;
	logic        left_event;
	logic [39:0] tag_id;
	logic [7:0]  tag_check;
	logic        check_ok;

	modport source (output valid, tag_state, left_event, tag_id, tag_check, check_ok,
		input ready);
	modport sink   (input valid, tag_state, left_event, tag_id, tag_check, check_ok,
		output ready);
endinterface

// ===== rtl/core/rfp_core.sv =====
// Parser state (mode, digit position, frame store) and the single-pass
// update that turns one word into one result. Depends on rfp_pkg.
module rfp_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  rfp_pkg::item_t  item,
	output rfp_pkg::result_t res
);
	import rfp_pkg::*;

	mode_t             mode_q, mode_n;
	logic [DPOS_W-1:0] dpos_q, dpos_n;
	logic [7:0]        frame_q [STORE_BYTES];
	logic [7:0]        frame_n [STORE_BYTES];
	logic [7:0]        report  [REPORT_BYTES];
	logic              left;
	logic [3:0]        nib;

	assign nib = hex_nibble(item.rx_byte);

	always_comb begin
		mode_n = mode_q;
		dpos_n = dpos_q;
		frame_n = frame_q;
		left = 1'b0;
		if (item.cmd == CMD_BYTE) begin
			if (mode_q == MODE_READING) begin
				if (item.rx_byte == BYTE_START) begin
					dpos_n = '0;
				end else if (dpos_q >= DPOS_W'(FRAME_DIGITS)) begin
					if (item.rx_byte == BYTE_END) begin
						mode_n = MODE_ARRIVED;
					end
				end else begin
					for (int k = 0; k < STORE_BYTES; k++) begin
						if (DPOS_W'(k) == (dpos_q >> 1)) begin
							if (dpos_q[0]) begin
								frame_n[k] = frame_q[k] | {4'h0, nib};
							end else begin
								frame_n[k] = {nib, 4'h0};
							end
						end
					end
					dpos_n = DPOS_W'(dpos_q + 1'b1);
				end
			end else begin
				// Any byte outside a frame ends a presence episode first.
				left = (mode_q == MODE_ARRIVED) || (mode_q == MODE_PRESENT);
				if (item.rx_byte == BYTE_START) begin
					dpos_n = '0;
					mode_n = MODE_READING;
				end else begin
					mode_n = MODE_IDLE;
				end
			end
		end else begin
			unique case (mode_q)
				MODE_LEFT: mode_n = MODE_IDLE;
				MODE_ARRIVED, MODE_PRESENT: begin
					if (item.card_present) begin
						mode_n = MODE_PRESENT;
					end else begin
						mode_n = MODE_LEFT;
						left = 1'b1;
					end
				end
				default: mode_n = mode_q;
			endcase
		end
	end

	for (genvar j = 0; j < REPORT_BYTES; j++) begin : g_report
		if (j < STORE_BYTES) begin : g_have
			assign report[j] = frame_n[j];
		end else begin : g_zero
			assign report[j] = '0;
		end
	end

	always_comb begin
		logic [7:0] x;
		x = '0;
		res.tag_id = '0;
		for (int i = 0; i < ID_BYTES; i++) begin
			res.tag_id = {res.tag_id[31:0], report[i]};
			x = x ^ report[i];
		end
		res.tag_check = report[ID_BYTES];
		res.check_ok = (x == report[ID_BYTES]);
		res.left_event = left;
		unique case (mode_n)
			MODE_READING: res.tag_state = TAG_READING;
			MODE_ARRIVED: res.tag_state = TAG_ARRIVED;
			MODE_PRESENT: res.tag_state = TAG_PRESENT;
			MODE_LEFT:    res.tag_state = TAG_LEFT;
			default:      res.tag_state = TAG_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			dpos_q <= '0;
			for (int k = 0; k < STORE_BYTES; k++) begin
				frame_q[k] <= '0;
			end
		end else if (step) begin
			mode_q <= mode_n;
			dpos_q <= dpos_n;
			frame_q <= frame_n;
		end
	end

endmodule

// ===== rtl/core/rfid_ascii_frame_parser_top.sv =====
// Top level of the RFID ASCII hex frame parser: input register, parser
// core and result register. Depends on rfp_pkg, rfp_ifs and rfp_core.
//
// Usage: every word on the item channel is either a received serial byte
// (cmd 0, rx_byte) or a poll tick (cmd 1, card_present). A frame is the
// start byte 0x02, twelve ASCII hex digits and the end byte 0x03; it makes
// the tag arrived, a poll makes it present, and a poll with the presence
// line low makes it left. Each input word yields exactly one result word
// with the tag state, the card-left event, the 40-bit id, its check byte
// and whether the XOR of the id bytes matches the check byte.
// An accepted word is registered in the input register, processed by the
// core and registered again in the result register, which presents it on
// the result channel. Throughput: one word per cycle while the receiver
// does not stall, as the core updates the mode, digit position and
// six-byte frame store for every word in one pass.
// Reset clears the mode to idle, the digit position and the frame store to
// zero, and empties both pipeline registers. When the receiver stalls,
// the result register holds its word and the input register holds one
// more; the item channel drops ready only when both are full.
module rfid_ascii_frame_parser_top (
	input  logic          clk,
	input  logic          arst_n,
	rfp_item_if.sink      item,
	rfp_result_if.source  result
);
	import rfp_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t result_q;
	result_t res;
	logic    advance;
	logic    step;

	// The pipeline moves whenever the result register is empty or drained.
	assign advance = !out_valid_q || result.ready;
	assign step = valid_s1 && advance;
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1 <= '{cmd: item.cmd, rx_byte: item.rx_byte,
				card_present: item.card_present};
		end
	end

	rfp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= res;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.tag_state  = result_q.tag_state;
	assign result.left_event = result_q.left_event;
	assign result.tag_id     = result_q.tag_id;
	assign result.tag_check  = result_q.tag_check;
	assign result.check_ok   = result_q.check_ok;

`ifndef ASSERT_OFF
	// A card-left event never comes with the tag still arrived or present.
	a_left_state: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.left_event) |->
		(result.tag_state != TAG_ARRIVED && result.tag_state != TAG_PRESENT))
		else $error("left event reported with tag still in place");

	// The check flag agrees with the reported id and check byte.
	a_check_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.check_ok ==
		((result.tag_id[39:32] ^ result.tag_id[31:24] ^ result.tag_id[23:16]
		^ result.tag_id[15:8] ^ result.tag_id[7:0]) == result.tag_check)))
		else $error("check flag disagrees with id and check byte");

	// An accepted word is held in the input register the next cycle.
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> valid_s1)
		else $error("accepted word lost before the input register");

	// A word waiting in the input register stays put while stalled.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)))
		else $error("stalled input word changed");
`endif

endmodule

// ===== tb/tb_rfid_ascii_frame_parser_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rfid_ascii_frame_parser_top: drives byte and poll words,
// predicts every result word and compares it field by field.
// Depends on rfp_pkg, rfp_ifs and the parser RTL.
module tb_rfid_ascii_frame_parser_top;
	import rfp_pkg::*;

	// The run is ended by a watchdog well beyond the slowest correct run.
	// That run is about 950 words, each waiting at most one long sender gap
	// and one long receiver stall, plus the one long hold-off.
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_WORDS = 900;
	// A word reaches the result channel through the input and result registers,
	// so the drain wait after the last result is enough to catch stray words.
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 80;
	localparam int MAX_PRINTED  = 50;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;

	// Tracks the tag state, the digit position and the frame store of the
	// parser, and keeps the result words that are still to come, oldest first.
	class tag_tracker;
		logic [2:0] mode;
		int         digit_pos;
		logic [7:0] frame_store [STORE_BYTES];
		result_t    awaited_reports [$];
		int         fails;
		int         checked;
		int         frames_done;
		int         left_events;
		int         good_checks;

		function new();
			mode = TAG_IDLE;
			digit_pos = 0;
			foreach (frame_store[i]) frame_store[i] = 8'h00;
			fails = 0;
			checked = 0;
			frames_done = 0;
			left_events = 0;
			good_checks = 0;
		endfunction

		function int pending();
			return awaited_reports.size();
		endfunction

		// Works out the result word for one accepted input word.
		function void predict_word(item_t w);
			result_t    r;
			logic [7:0] v;
			logic [7:0] x;
			int         slot;
			int         i;
			r = '0;
			if (w.cmd == CMD_BYTE) begin
				// A byte while a tag is held means the card has gone.
				if (mode == TAG_ARRIVED || mode == TAG_PRESENT) begin
					r.left_event = 1'b1;
					mode = TAG_IDLE;
				end else if (mode == TAG_LEFT) begin
					mode = TAG_IDLE;
				end
				if (mode == TAG_IDLE) begin
					if (w.rx_byte == BYTE_START) begin
						digit_pos = 0;
						mode = TAG_READING;
					end
				end else if (w.rx_byte == BYTE_START) begin
					digit_pos = 0;
				end else if (digit_pos >= FRAME_DIGITS) begin
					if (w.rx_byte == BYTE_END) begin
						mode = TAG_ARRIVED;
						frames_done++;
					end
				end else begin
					v = w.rx_byte - CHAR_ZERO;
					if (v > 8'd9) begin
						v = w.rx_byte - CHAR_A + 8'd10;
					end
					slot = digit_pos / 2;
					if (digit_pos % 2 == 1) begin
						frame_store[slot] = frame_store[slot] | {4'h0, v[3:0]};
					end else begin
						frame_store[slot] = {v[3:0], 4'h0};
					end
					digit_pos++;
				end
			end else begin
				if (mode == TAG_LEFT) begin
					mode = TAG_IDLE;
				end else if (mode == TAG_ARRIVED || mode == TAG_PRESENT) begin
					mode = TAG_PRESENT;
					if (!w.card_present) begin
						mode = TAG_LEFT;
						r.left_event = 1'b1;
					end
				end
			end
			r.tag_state = mode;
			x = 8'h00;
			for (i = 0; i < ID_BYTES; i++) begin
				r.tag_id = {r.tag_id[31:0], frame_store[i]};
				x = x ^ frame_store[i];
			end
			r.tag_check = frame_store[ID_BYTES];
			r.check_ok = (x == frame_store[ID_BYTES]);
			if (r.left_event) left_events++;
			if (mode == TAG_ARRIVED && r.check_ok) good_checks++;
			awaited_reports.push_back(r);
		endfunction

		task report(string msg);
			if (fails < MAX_PRINTED) begin
				$display("MISMATCH: %s", msg);
			end
			fails++;
		endtask

		// Compares one accepted result word with the oldest prediction.
		task compare_report(result_t got);
			result_t want;
			if (awaited_reports.size() == 0) begin
				report($sformatf("result word with no input word waiting (state %0d)",
					got.tag_state));
				return;
			end
			want = awaited_reports.pop_front();
			checked++;
			if (got.tag_state !== want.tag_state)
				report($sformatf("word %0d tag_state %0d, want %0d",
					checked, got.tag_state, want.tag_state));
			if (got.left_event !== want.left_event)
				report($sformatf("word %0d left_event %0b, want %0b",
					checked, got.left_event, want.left_event));
			if (got.tag_id !== want.tag_id)
				report($sformatf("word %0d tag_id %h, want %h",
					checked, got.tag_id, want.tag_id));
			if (got.tag_check !== want.tag_check)
				report($sformatf("word %0d tag_check %h, want %h",
					checked, got.tag_check, want.tag_check));
			if (got.check_ok !== want.check_ok)
				report($sformatf("word %0d check_ok %0b, want %0b",
					checked, got.check_ok, want.check_ok));
		endtask
	endclass

	logic clk;
	logic arst_n;
	rfp_item_if   item_ch ();
	rfp_result_if result_ch ();

	rfid_ascii_frame_parser_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	tag_tracker tracker = new();

	// Flags shared between the sender and the receiver. burst_mode turns off
	// random idling on both sides; hold_req asks the receiver for a long
	// hold-off so that the parser fills up and drops ready on its input.
	bit hold_req   = 1'b0;
	bit burst_mode = 1'b0;
	int words_sent = 0;
	int cycles     = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Idle length for either side: mostly none or short, now and then long.
	function int idle_len();
		int r;
		if (burst_mode) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	// ASCII hex character for one nibble, in upper or lower case. The lower
	// case letters decode to the same nibbles, since only the low four bits
	// of the decoded value are kept.
	function logic [7:0] hex_char(logic [3:0] n, bit lower);
		if (n < 4'd10) return CHAR_ZERO + n;
		return (lower ? CHAR_LOWER_A : CHAR_A) + n - 8'd10;
	endfunction

	// Offers one word and holds it until the parser takes it. After the
	// accepting edge valid is lowered only if a gap follows; with no gap the
	// next word's payload is set in the same step and valid simply stays high.
	task send_word(item_t w);
		int gap;
		item_ch.valid        <= 1'b1;
		item_ch.cmd          <= w.cmd;
		item_ch.rx_byte      <= w.rx_byte;
		item_ch.card_present <= w.card_present;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		tracker.predict_word(w);
		words_sent++;
		gap = idle_len();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// A byte word; the presence bit is random since the parser ignores it.
	task send_byte(logic [7:0] b);
		item_t w;
		w.cmd = CMD_BYTE;
		w.rx_byte = b;
		w.card_present = 1'($urandom_range(0, 1));
		send_word(w);
	endtask

	// A poll word; the byte field is random since the parser ignores it.
	task send_poll(logic present);
		item_t w;
		w.cmd = CMD_POLL;
		w.rx_byte = 8'($urandom_range(0, 255));
		w.card_present = present;
		send_word(w);
	endtask

	// One frame with random content: start byte, twelve digits and end byte.
	// Some frames restart partway, carry a stray byte in place of a digit,
	// carry an extra byte before the end, or lose the end byte entirely.
	task send_tag(logic [39:0] id, bit good_check);
		logic [47:0] body;
		logic [7:0]  c;
		int          i;
		body = {id, good_check ? (id[39:32] ^ id[31:24] ^ id[23:16] ^ id[15:8] ^ id[7:0])
			: 8'($urandom_range(0, 255))};
		send_byte(BYTE_START);
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 11))
				send_byte(hex_char(4'($urandom_range(0, 15)), 1'b0));
			send_byte(BYTE_START);
		end
		for (i = 0; i < FRAME_DIGITS; i++) begin
			if ($urandom_range(0, 19) == 0) begin
				c = 8'($urandom_range(0, 255));
			end else begin
				c = hex_char(body[47 - 4 * i -: 4], $urandom_range(0, 3) == 0);
			end
			send_byte(c);
		end
		if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 9) != 0) send_byte(BYTE_END);
	endtask

	function logic [39:0] random_id();
		logic [63:0] raw;
		raw = {$urandom(), $urandom()};
		return raw[39:0];
	endfunction

	// Receiver: takes result words, stalls at random and serves the long
	// hold-off when the sender asks for it. The hold-off is counted here.
	initial begin
		int stall_left;
		int hold_left;
		result_t got;
		stall_left = 0;
		hold_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				got.tag_state  = result_ch.tag_state;
				got.left_event = result_ch.left_event;
				got.tag_id     = result_ch.tag_id;
				got.tag_check  = result_ch.tag_check;
				got.check_ok   = result_ch.check_ok;
				tracker.compare_report(got);
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) stall_left = idle_len();
			end
		end
	end

	// Watchdog: a hung handshake or a lost word ends the run here.
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles with %0d result words outstanding",
			cycles, tracker.pending());
		$display("Verification failed");
		$finish;
	end

	// Main sequence: reset, a directed walk through the tag states, then
	// random traffic that is mostly well-formed frames with random content.
	initial begin
		int  r;
		int  random_end;
		bit  pressed;
		pressed = 1'b0;
		arst_n               <= 1'b0;
		item_ch.valid        <= 1'b0;
		item_ch.cmd          <= CMD_BYTE;
		item_ch.rx_byte      <= 8'h00;
		item_ch.card_present <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Idle: bytes other than the start byte are dropped, polls do nothing.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_poll(1'b1);
		// Reading: a poll changes nothing, and a second start byte throws the
		// partial frame away.
		send_byte(BYTE_START);
		send_poll(1'b0);
		send_byte("9");
		send_byte("A");
		send_byte(BYTE_START);
		// Twelve digits, then a byte that is dropped because the frame is
		// full, then the end byte that makes the tag arrived.
		send_byte("0");
		send_byte("1");
		send_byte("2");
		send_byte("3");
		send_byte("4");
		send_byte("5");
		send_byte("6");
		send_byte("7");
		send_byte("8");
		send_byte("9");
		send_byte("A");
		send_byte("F");
		send_byte(CHAR_A);
		send_byte(BYTE_END);
		// Arrived to present, present to left with the line low, left to idle.
		send_poll(1'b1);
		send_poll(1'b0);
		send_poll(1'b1);

		random_end = words_sent + RANDOM_WORDS;
		while (words_sent < random_end) begin
			// Once, the receiver holds off for a long stretch while the sender
			// keeps offering words back to back, so the input stalls.
			if (!pressed && words_sent >= 300) begin
				pressed = 1'b1;
				hold_req = 1'b1;
				burst_mode = 1'b1;
				send_tag(random_id(), 1'b1);
			end
			// A stretch of traffic with no idling on either side.
			burst_mode = (words_sent >= 550 && words_sent < 650);
			r = $urandom_range(0, 99);
			if (r < 70) begin
				send_tag(random_id(), $urandom_range(0, 9) < 6);
				// After a frame: some polls, then maybe a byte that signals the
				// card has left, either a new start byte or noise.
				repeat ($urandom_range(0, 3)) send_poll($urandom_range(0, 9) < 7);
				case ($urandom_range(0, 3))
					0: begin
						send_byte(BYTE_START);
					end
					1: begin
						send_byte(8'($urandom_range(0, 255)));
					end
					default: begin
					end
				endcase
			end else if (r < 88) begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 3)) send_poll(1'($urandom_range(0, 1)));
			end
		end
		burst_mode = 1'b0;
		// The last word is taken at this edge; lower valid so it is not taken twice.
		item_ch.valid <= 1'b0;

		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d input words and checked %0d result words.",
			words_sent, tracker.checked);
		$display("Frames completed: %0d (%0d with a matching check byte), card-left events: %0d.",
			tracker.frames_done, tracker.good_checks, tracker.left_events);
		if (tracker.fails == 0 && tracker.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/rfp_pkg.sv
rtl/core/rfp_ifs.sv
rtl/core/rfp_core.sv
rtl/core/rfid_ascii_frame_parser_top.sv
tb/tb_rfid_ascii_frame_parser_top.sv
